FILE: hw/rtl/p2sd_pkg.sv
// ----------------------------------------------------------------------------
// p2sd_pkg
// Shared types and codes for the point to segment distance unit.
// ----------------------------------------------------------------------------
package p2sd_pkg;

    // Which part of the segment is nearest to the query point.
    localparam logic [1:0] PART_FOOT  = 2'd0;
    localparam logic [1:0] PART_START = 2'd1;
    localparam logic [1:0] PART_END   = 2'd2;

    // Configuration register indexes.
    localparam int unsigned REG_IDX_WIDTH = 3;
    localparam logic [REG_IDX_WIDTH-1:0] REG_START_X = 3'd0;
    localparam logic [REG_IDX_WIDTH-1:0] REG_START_Y = 3'd1;
    localparam logic [REG_IDX_WIDTH-1:0] REG_START_Z = 3'd2;
    localparam logic [REG_IDX_WIDTH-1:0] REG_END_X   = 3'd3;
    localparam logic [REG_IDX_WIDTH-1:0] REG_END_Y   = 3'd4;
    localparam logic [REG_IDX_WIDTH-1:0] REG_END_Z   = 3'd5;

    // Control that travels with every request down the chain.
    typedef struct packed {
        logic       valid;
        logic [1:0] part;
    } p2sd_ctl_t;

endpackage

FILE: hw/rtl/p2sd_front.sv
// ----------------------------------------------------------------------------
// p2sd_front
// Six stage front end: differences, products, dot and cross terms, case
// selection with partial products of the squared cross terms, the squared
// cross terms, and the numerator and denominator of the squared distance.
// ----------------------------------------------------------------------------
module p2sd_front
    import p2sd_pkg::*;
#(
    parameter int COORD_WIDTH = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [COORD_WIDTH-1:0] sx,
    input  logic signed [COORD_WIDTH-1:0] sy,
    input  logic signed [COORD_WIDTH-1:0] sz,
    input  logic signed [COORD_WIDTH-1:0] ex,
    input  logic signed [COORD_WIDTH-1:0] ey,
    input  logic signed [COORD_WIDTH-1:0] ez,
    input  logic signed [COORD_WIDTH-1:0] px,
    input  logic signed [COORD_WIDTH-1:0] py,
    input  logic signed [COORD_WIDTH-1:0] pz,
    output p2sd_ctl_t                     ctl,
    output logic [4*COORD_WIDTH+3:0]      num,
    output logic [2*COORD_WIDTH+1:0]      den
);

    localparam int DW   = COORD_WIDTH + 1;
    localparam int PW   = 2 * DW;
    localparam int CW   = PW + 1;
    localparam int NW   = 4 * COORD_WIDTH + 4;
    localparam int DENW = 2 * COORD_WIDTH + 2;
    localparam int HW   = CW - DW;
    localparam int HLW  = HW + DW + 1;
    localparam int SQW  = 2 * CW;

    // Stage 1: differences.
    logic               v1_reg;
    logic signed [DW-1:0] dx_reg, dy_reg, dz_reg, wx_reg, wy_reg, wz_reg;
    logic signed [DW-1:0] vx_reg, vy_reg, vz_reg;

    // Stage 2: products.
    logic               v2_reg;
    logic signed [PW-1:0] ddx_reg, ddy_reg, ddz_reg, wdx_reg, wdy_reg, wdz_reg;
    logic signed [PW-1:0] wwx_reg, wwy_reg, wwz_reg, vvx_reg, vvy_reg, vvz_reg;
    logic signed [PW-1:0] c1a_reg, c1b_reg, c2a_reg, c2b_reg, c3a_reg, c3b_reg;

    // Stage 3: sums and cross product.
    logic                 v3_reg;
    logic [DENW-1:0]      len2_reg, ww_reg, vv_reg;
    logic signed [PW+1:0] dot_reg;
    logic signed [CW-1:0] cx_reg, cy_reg, cz_reg;

    // Stage 4: case and partial products of the squared cross terms. Each
    // cross term is split into a signed high part and an unsigned low part.
    p2sd_ctl_t              c4_reg;
    logic signed [2*HW-1:0] hhx_reg, hhy_reg, hhz_reg;
    logic signed [HLW-1:0]  hlx_reg, hly_reg, hlz_reg;
    logic [2*DW-1:0]        llx_reg, lly_reg, llz_reg;
    logic [DENW-1:0]        len4_reg, ww4_reg, vv4_reg;

    // Stage 5: squared cross terms.
    p2sd_ctl_t       c5_reg;
    logic [SQW-1:0]  sqx_reg, sqy_reg, sqz_reg;
    logic [DENW-1:0] len5_reg, ww5_reg, vv5_reg;

    // Stage 6: output.
    p2sd_ctl_t       c6_reg;
    logic [NW-1:0]   num_reg;
    logic [DENW-1:0] den_reg;

    logic signed [PW+1:0] len2_s, ww_s, vv_s, dot_s;
    logic [1:0]           part_next;
    logic [2*CW+1:0]      sq_sum;
    logic signed [HW-1:0] hx, hy, hz;
    logic [DW-1:0]        lx, ly, lz;

    // Reassembles hi^2 * 2^(2*DW) + 2 * hi * lo * 2^DW + lo^2. The true value
    // is never negative, so the wrapped sum is exact.
    function automatic logic [SQW-1:0] join_square(logic [2*HW-1:0] hh,
                                                   logic [HLW-1:0]  hl,
                                                   logic [2*DW-1:0] ll);
        return ({{(SQW-2*HW){hh[2*HW-1]}}, hh} << (2*DW))
             + ({{(SQW-HLW){hl[HLW-1]}}, hl} << (DW+1))
             + {{(SQW-2*DW){1'b0}}, ll};
    endfunction

    assign len2_s = {{2{ddx_reg[PW-1]}}, ddx_reg} + {{2{ddy_reg[PW-1]}}, ddy_reg}
                  + {{2{ddz_reg[PW-1]}}, ddz_reg};
    assign ww_s   = {{2{wwx_reg[PW-1]}}, wwx_reg} + {{2{wwy_reg[PW-1]}}, wwy_reg}
                  + {{2{wwz_reg[PW-1]}}, wwz_reg};
    assign vv_s   = {{2{vvx_reg[PW-1]}}, vvx_reg} + {{2{vvy_reg[PW-1]}}, vvy_reg}
                  + {{2{vvz_reg[PW-1]}}, vvz_reg};
    assign dot_s  = {{2{wdx_reg[PW-1]}}, wdx_reg} + {{2{wdy_reg[PW-1]}}, wdy_reg}
                  + {{2{wdz_reg[PW-1]}}, wdz_reg};

    assign hx = cx_reg[CW-1:DW];
    assign hy = cy_reg[CW-1:DW];
    assign hz = cz_reg[CW-1:DW];
    assign lx = cx_reg[DW-1:0];
    assign ly = cy_reg[DW-1:0];
    assign lz = cz_reg[DW-1:0];

    always_comb
    begin
        if ((len2_reg == '0) || dot_reg[PW+1])
        begin
            part_next = PART_START;
        end
        else if (dot_reg > $signed({2'b00, len2_reg}))
        begin
            part_next = PART_END;
        end
        else
        begin
            part_next = PART_FOOT;
        end
    end

    assign sq_sum = {2'b00, sqx_reg} + {2'b00, sqy_reg} + {2'b00, sqz_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            c4_reg <= '0;
            c5_reg <= '0;
            c6_reg <= '0;
        end
        else if (en)
        begin
            v1_reg       <= in_valid;
            v2_reg       <= v1_reg;
            v3_reg       <= v2_reg;
            c4_reg.valid <= v3_reg;
            c4_reg.part  <= part_next;
            c5_reg       <= c4_reg;
            c6_reg       <= c5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg <= {ex[COORD_WIDTH-1], ex} - {sx[COORD_WIDTH-1], sx};
            dy_reg <= {ey[COORD_WIDTH-1], ey} - {sy[COORD_WIDTH-1], sy};
            dz_reg <= {ez[COORD_WIDTH-1], ez} - {sz[COORD_WIDTH-1], sz};
            wx_reg <= {px[COORD_WIDTH-1], px} - {sx[COORD_WIDTH-1], sx};
            wy_reg <= {py[COORD_WIDTH-1], py} - {sy[COORD_WIDTH-1], sy};
            wz_reg <= {pz[COORD_WIDTH-1], pz} - {sz[COORD_WIDTH-1], sz};
            vx_reg <= {px[COORD_WIDTH-1], px} - {ex[COORD_WIDTH-1], ex};
            vy_reg <= {py[COORD_WIDTH-1], py} - {ey[COORD_WIDTH-1], ey};
            vz_reg <= {pz[COORD_WIDTH-1], pz} - {ez[COORD_WIDTH-1], ez};

            ddx_reg <= PW'(dx_reg * dx_reg);
            ddy_reg <= PW'(dy_reg * dy_reg);
            ddz_reg <= PW'(dz_reg * dz_reg);
            wdx_reg <= PW'(wx_reg * dx_reg);
            wdy_reg <= PW'(wy_reg * dy_reg);
            wdz_reg <= PW'(wz_reg * dz_reg);
            wwx_reg <= PW'(wx_reg * wx_reg);
            wwy_reg <= PW'(wy_reg * wy_reg);
            wwz_reg <= PW'(wz_reg * wz_reg);
            vvx_reg <= PW'(vx_reg * vx_reg);
            vvy_reg <= PW'(vy_reg * vy_reg);
            vvz_reg <= PW'(vz_reg * vz_reg);
            c1a_reg <= PW'(wy_reg * dz_reg);
            c1b_reg <= PW'(wz_reg * dy_reg);
            c2a_reg <= PW'(wz_reg * dx_reg);
            c2b_reg <= PW'(wx_reg * dz_reg);
            c3a_reg <= PW'(wx_reg * dy_reg);
            c3b_reg <= PW'(wy_reg * dx_reg);

            len2_reg <= len2_s[DENW-1:0];
            ww_reg   <= ww_s[DENW-1:0];
            vv_reg   <= vv_s[DENW-1:0];
            dot_reg  <= dot_s;
            cx_reg   <= {c1a_reg[PW-1], c1a_reg} - {c1b_reg[PW-1], c1b_reg};
            cy_reg   <= {c2a_reg[PW-1], c2a_reg} - {c2b_reg[PW-1], c2b_reg};
            cz_reg   <= {c3a_reg[PW-1], c3a_reg} - {c3b_reg[PW-1], c3b_reg};

            hhx_reg  <= hx * hx;
            hhy_reg  <= hy * hy;
            hhz_reg  <= hz * hz;
            hlx_reg  <= HLW'(hx * $signed({1'b0, lx}));
            hly_reg  <= HLW'(hy * $signed({1'b0, ly}));
            hlz_reg  <= HLW'(hz * $signed({1'b0, lz}));
            llx_reg  <= lx * lx;
            lly_reg  <= ly * ly;
            llz_reg  <= lz * lz;
            len4_reg <= len2_reg;
            ww4_reg  <= ww_reg;
            vv4_reg  <= vv_reg;

            sqx_reg  <= join_square(hhx_reg, hlx_reg, llx_reg);
            sqy_reg  <= join_square(hhy_reg, hly_reg, lly_reg);
            sqz_reg  <= join_square(hhz_reg, hlz_reg, llz_reg);
            len5_reg <= len4_reg;
            ww5_reg  <= ww4_reg;
            vv5_reg  <= vv4_reg;

            case (c5_reg.part)
                PART_FOOT:
                begin
                    num_reg <= sq_sum[NW-1:0];
                    den_reg <= len5_reg;
                end
                PART_END:
                begin
                    num_reg <= NW'(vv5_reg);
                    den_reg <= DENW'(1);
                end
                default:
                begin
                    num_reg <= NW'(ww5_reg);
                    den_reg <= DENW'(1);
                end
            endcase
        end
    end

    assign ctl = c6_reg;
    assign num = num_reg;
    assign den = den_reg;

endmodule

FILE: hw/rtl/p2sd_div_cell.sv
// ----------------------------------------------------------------------------
// p2sd_div_cell
// One restoring division step: produces one quotient bit per cell.
// ----------------------------------------------------------------------------
module p2sd_div_cell
    import p2sd_pkg::*;
#(
    parameter int DENW = 66,
    parameter int QW   = 66
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  p2sd_ctl_t       ctl_in,
    input  logic [DENW-1:0] rem_in,
    input  logic [QW-1:0]   q_in,
    input  logic [DENW-1:0] den_in,
    output p2sd_ctl_t       ctl_out,
    output logic [DENW-1:0] rem_out,
    output logic [QW-1:0]   q_out,
    output logic [DENW-1:0] den_out
);

    p2sd_ctl_t       ctl_reg;
    logic [DENW-1:0] rem_reg, den_reg;
    logic [QW-1:0]   q_reg;
    logic [DENW:0]   trial;
    logic            fits;

    assign trial = {rem_in, q_in[QW-1]};
    assign fits  = (trial >= {1'b0, den_in});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= fits ? DENW'(trial - {1'b0, den_in}) : trial[DENW-1:0];
            q_reg   <= {q_in[QW-2:0], fits};
            den_reg <= den_in;
        end
    end

    assign ctl_out = ctl_reg;
    assign rem_out = rem_reg;
    assign q_out   = q_reg;
    assign den_out = den_reg;

endmodule

FILE: hw/rtl/p2sd_sqrt_cell.sv
// ----------------------------------------------------------------------------
// p2sd_sqrt_cell
// One digit-by-digit square root step: produces one root bit per cell.
// ----------------------------------------------------------------------------
module p2sd_sqrt_cell
    import p2sd_pkg::*;
#(
    parameter int RW = 33,
    parameter int QW = 66
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  p2sd_ctl_t     ctl_in,
    input  logic [RW+1:0] rem_in,
    input  logic [RW-1:0] root_in,
    input  logic [QW-1:0] rad_in,
    output p2sd_ctl_t     ctl_out,
    output logic [RW+1:0] rem_out,
    output logic [RW-1:0] root_out,
    output logic [QW-1:0] rad_out
);

    p2sd_ctl_t     ctl_reg;
    logic [RW+1:0] rem_reg;
    logic [RW-1:0] root_reg;
    logic [QW-1:0] rad_reg;
    logic [RW+3:0] t;
    logic [RW+3:0] trial;
    logic          fits;

    assign t     = {rem_in, rad_in[QW-1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign fits  = (t >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= fits ? (RW+2)'(t - trial) : t[RW+1:0];
            root_reg <= {root_in[RW-2:0], fits};
            rad_reg  <= {rad_in[QW-3:0], 2'b00};
        end
    end

    assign ctl_out  = ctl_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign rad_out  = rad_reg;

endmodule

FILE: hw/rtl/point_to_segment_distance_3d_unit.sv
// ----------------------------------------------------------------------------
// Pipeline: six front-end stages, one division cell per quotient bit and one
// root cell per result bit. Throughput: one request per cycle; the whole
// chain holds while a result waits on out_stall. Reset clears all valid bits
// and the segment registers.
// ----------------------------------------------------------------------------
// point_to_segment_distance_3d_unit
// Distance from a query point to a configured 3D segment, Q16.16 in, Q17.16
// out, truncated, with the nearest part of the segment reported.
// ----------------------------------------------------------------------------
module point_to_segment_distance_3d_unit
    import p2sd_pkg::*;
#(
    parameter int COORD_WIDTH = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [REG_IDX_WIDTH-1:0]      cfg_index,
    input  logic [COORD_WIDTH-1:0]        cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] query_x,
    input  logic signed [COORD_WIDTH-1:0] query_y,
    input  logic signed [COORD_WIDTH-1:0] query_z,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [COORD_WIDTH:0]          distance,
    output logic [1:0]                    nearest_part
);

    // The squared distance is formed as an exact ratio num/den. The quotient
    // is below 2^(2W+2), so the integer root always fits W+1 bits and the
    // output never actually reaches saturation. Taking the floor of the ratio
    // before the root does not change the floor of the root.
    localparam int NW   = 4 * COORD_WIDTH + 4;
    localparam int DENW = 2 * COORD_WIDTH + 2;
    localparam int QW   = 2 * COORD_WIDTH + 2;
    localparam int RW   = COORD_WIDTH + 1;

    logic signed [COORD_WIDTH-1:0] start_x_reg, start_y_reg, start_z_reg;
    logic signed [COORD_WIDTH-1:0] end_x_reg, end_y_reg, end_z_reg;
    logic en;

    // Configuration is always accepted; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg <= '0;
            start_y_reg <= '0;
            start_z_reg <= '0;
            end_x_reg   <= '0;
            end_y_reg   <= '0;
            end_z_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_START_X: start_x_reg <= cfg_data;
                REG_START_Y: start_y_reg <= cfg_data;
                REG_START_Z: start_z_reg <= cfg_data;
                REG_END_X:   end_x_reg   <= cfg_data;
                REG_END_Y:   end_y_reg   <= cfg_data;
                REG_END_Z:   end_z_reg   <= cfg_data;
                default:     ;
            endcase
        end
    end

    // The chain moves as one unit unless the finished result is held.
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    p2sd_ctl_t       f_ctl;
    logic [NW-1:0]   f_num;
    logic [DENW-1:0] f_den;

    p2sd_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .sx       (start_x_reg),
        .sy       (start_y_reg),
        .sz       (start_z_reg),
        .ex       (end_x_reg),
        .ey       (end_y_reg),
        .ez       (end_z_reg),
        .px       (query_x),
        .py       (query_y),
        .pz       (query_z),
        .ctl      (f_ctl),
        .num      (f_num),
        .den      (f_den)
    );

    // Division chain: one quotient bit per cell, most significant first.
    p2sd_ctl_t       d_ctl [QW+1];
    logic [DENW-1:0] d_rem [QW+1];
    logic [QW-1:0]   d_q   [QW+1];
    logic [DENW-1:0] d_den [QW+1];

    assign d_ctl[0] = f_ctl;
    assign d_rem[0] = f_num[NW-1:QW];
    assign d_q[0]   = f_num[QW-1:0];
    assign d_den[0] = f_den;

    for (genvar i = 0; i < QW; i++)
    begin : g_div
        p2sd_div_cell #(.DENW(DENW), .QW(QW)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .ctl_in  (d_ctl[i]),
            .rem_in  (d_rem[i]),
            .q_in    (d_q[i]),
            .den_in  (d_den[i]),
            .ctl_out (d_ctl[i+1]),
            .rem_out (d_rem[i+1]),
            .q_out   (d_q[i+1]),
            .den_out (d_den[i+1])
        );
    end

    // Square root chain: one root bit per cell, two radicand bits consumed.
    p2sd_ctl_t     s_ctl  [RW+1];
    logic [RW+1:0] s_rem  [RW+1];
    logic [RW-1:0] s_root [RW+1];
    logic [QW-1:0] s_rad  [RW+1];

    assign s_ctl[0]  = d_ctl[QW];
    assign s_rem[0]  = '0;
    assign s_root[0] = '0;
    assign s_rad[0]  = d_q[QW];

    for (genvar k = 0; k < RW; k++)
    begin : g_sqrt
        p2sd_sqrt_cell #(.RW(RW), .QW(QW)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .ctl_in   (s_ctl[k]),
            .rem_in   (s_rem[k]),
            .root_in  (s_root[k]),
            .rad_in   (s_rad[k]),
            .ctl_out  (s_ctl[k+1]),
            .rem_out  (s_rem[k+1]),
            .root_out (s_root[k+1]),
            .rad_out  (s_rad[k+1])
        );
    end

    assign out_valid    = s_ctl[RW].valid;
    assign distance     = s_root[RW];
    assign nearest_part = s_ctl[RW].part;

    // A result never carries the unused part code.
    a_part_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (nearest_part == PART_FOOT || nearest_part == PART_START
                       || nearest_part == PART_END))
        else $error("illegal nearest_part code");

    // A held result keeps its value and the input side is stalled.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(distance))
        else $error("held result changed");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input accepted while chain is held");

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the point to segment distance unit. A predictor
// works out the exact truncated distance and the nearest part for every
// accepted request, and a monitor compares each result against them in order.
// ----------------------------------------------------------------------------
module tb_top
    import p2sd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = 32;
    // Pipeline depth plus a margin; used before configuration writes and at the end.
    localparam int DRAIN_CYCLES = 3 * CW + 9 + 16;

    typedef logic signed [255:0] big_t;

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } point_t;

    typedef struct {
        logic [CW:0] span;
        logic [1:0]  part;
    } answer_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [REG_IDX_WIDTH-1:0] cfg_index;
    logic [CW-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic signed [CW-1:0] query_x;
    logic signed [CW-1:0] query_y;
    logic signed [CW-1:0] query_z;
    logic out_valid;
    logic out_stall;
    logic [CW:0] distance;
    logic [1:0] nearest_part;

    point_to_segment_distance_3d_unit #(.COORD_WIDTH(CW)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .query_x      (query_x),
        .query_y      (query_y),
        .query_z      (query_z),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .distance     (distance),
        .nearest_part (nearest_part)
    );

    // The bench's own copy of the segment registers, indexed like the block's.
    logic signed [CW-1:0] seg_reg [6];

    point_t  query_backlog [$];
    answer_t pending_answers [$];
    int      error_count;
    int      cycle_count;
    bit      req_taken;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Exact distance from a point to the configured segment. Wide integers keep
    // every product exact, so the only rounding is the final truncation.
    function automatic answer_t segment_distance(point_t p);
        big_t sx, sy, sz, ex, ey, ez, px, py, pz;
        big_t dx, dy, dz, wx, wy, wz, vx, vy, vz;
        big_t len2, dotp, num, den, cx, cy, cz, root, cand;
        answer_t a;
        sx = seg_reg[REG_START_X];
        sy = seg_reg[REG_START_Y];
        sz = seg_reg[REG_START_Z];
        ex = seg_reg[REG_END_X];
        ey = seg_reg[REG_END_Y];
        ez = seg_reg[REG_END_Z];
        px = p.x;
        py = p.y;
        pz = p.z;
        dx = ex - sx;
        dy = ey - sy;
        dz = ez - sz;
        wx = px - sx;
        wy = py - sy;
        wz = pz - sz;
        len2 = dx * dx + dy * dy + dz * dz;
        dotp = wx * dx + wy * dy + wz * dz;
        if (len2 == 0 || dotp < 0)
        begin
            // Degenerate segment or projection before the start point.
            num = wx * wx + wy * wy + wz * wz;
            den = 1;
            a.part = PART_START;
        end
        else if (dotp > len2)
        begin
            vx = px - ex;
            vy = py - ey;
            vz = pz - ez;
            num = vx * vx + vy * vy + vz * vz;
            den = 1;
            a.part = PART_END;
        end
        else
        begin
            // Foot inside, ends included: |w x d|^2 / |d|^2.
            cx = wy * dz - wz * dy;
            cy = wz * dx - wx * dz;
            cz = wx * dy - wy * dx;
            num = cx * cx + cy * cy + cz * cz;
            den = len2;
            a.part = PART_FOOT;
        end
        // Bit-by-bit square root of the ratio; the top bit search saturates
        // naturally at the all-ones result.
        root = 0;
        for (int b = CW; b >= 0; b--)
        begin
            cand = root | (big_t'(1) << b);
            if (cand * cand * den <= num)
                root = cand;
        end
        a.span = root[CW:0];
        return a;
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] error: %s", $realtime, what);
        error_count++;
    endtask

    // Both sides idle with a chance of about 16 in 100, except in one long calm window.
    function automatic bit take_a_gap();
        if (cycle_count >= 3000 && cycle_count < 6000)
            return 1'b0;
        return $urandom_range(99) < 16;
    endfunction

    // Request acceptance and result checking, on the rising edge.
    always @(posedge clk)
    begin
        point_t p;
        answer_t want;
        cycle_count++;
        req_taken = in_valid && !in_stall;
        if (rst_n && req_taken)
        begin
            p.x = query_x;
            p.y = query_y;
            p.z = query_z;
            pending_answers.push_back(segment_distance(p));
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_answers.size() == 0)
                report_mismatch("result with no request outstanding");
            else
            begin
                want = pending_answers.pop_front();
                if (distance !== want.span)
                    report_mismatch($sformatf("distance %0h, expected %0h",
                                              distance, want.span));
                if (nearest_part !== want.part)
                    report_mismatch($sformatf("nearest_part %0d, expected %0d",
                                              nearest_part, want.part));
            end
        end
    end

    // Request driver: holds a stalled request, otherwise either idles or
    // presents the next query from the backlog.
    always @(negedge clk)
    begin
        point_t p;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!(in_valid && !req_taken))
        begin
            if (query_backlog.size() != 0 && !take_a_gap())
            begin
                p = query_backlog.pop_front();
                in_valid <= 1'b1;
                query_x <= p.x;
                query_y <= p.y;
                query_z <= p.z;
            end
            else
                in_valid <= 1'b0;
        end
        out_stall <= take_a_gap();
    end

    // One register write through the configuration channel.
    task automatic write_reg(logic [REG_IDX_WIDTH-1:0] idx, logic [CW-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_START_X, REG_START_Y, REG_START_Z,
            REG_END_X, REG_END_Y, REG_END_Z: seg_reg[idx] = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_segment(point_t s, point_t e);
        write_reg(REG_START_X, s.x);
        write_reg(REG_START_Y, s.y);
        write_reg(REG_START_Z, s.z);
        write_reg(REG_END_X, e.x);
        write_reg(REG_END_Y, e.y);
        write_reg(REG_END_Z, e.z);
    endtask

    // Waits until every queued request has gone in and every result is back,
    // then lets the pipeline settle.
    task automatic drain();
        while (query_backlog.size() != 0 || in_valid || pending_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic point_t mk(longint x, longint y, longint z);
        point_t p;
        p.x = x[CW-1:0];
        p.y = y[CW-1:0];
        p.z = z[CW-1:0];
        return p;
    endfunction

    function automatic point_t any_point();
        return mk(longint'($urandom), longint'($urandom), longint'($urandom));
    endfunction

    // A point near the segment: somewhere along it, a little past either end,
    // plus a random offset. Most random queries look like this.
    function automatic point_t near_segment();
        longint k, jit;
        point_t p;
        k = longint'($urandom_range(320)) - 32;
        jit = longint'(1) << $urandom_range(20);
        p.x = CW'(seg_reg[REG_START_X]
              + ((longint'(seg_reg[REG_END_X]) - seg_reg[REG_START_X]) * k) / 256
              + longint'($urandom_range(2 * jit)) - jit);
        p.y = CW'(seg_reg[REG_START_Y]
              + ((longint'(seg_reg[REG_END_Y]) - seg_reg[REG_START_Y]) * k) / 256
              + longint'($urandom_range(2 * jit)) - jit);
        p.z = CW'(seg_reg[REG_START_Z]
              + ((longint'(seg_reg[REG_END_Z]) - seg_reg[REG_START_Z]) * k) / 256
              + longint'($urandom_range(2 * jit)) - jit);
        return p;
    endfunction

    task automatic random_queries(int count);
        for (int i = 0; i < count; i++)
            query_backlog.push_back($urandom_range(99) < 70 ? near_segment() : any_point());
        drain();
    endtask

    localparam longint MAXC = 64'sd2147483647;
    localparam longint MINC = -64'sd2147483648;

    initial
    begin
        point_t s, e;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        query_x = '0;
        query_y = '0;
        query_z = '0;
        out_stall = 1'b0;
        error_count = 0;
        cycle_count = 0;
        for (int i = 0; i < 6; i++)
            seg_reg[i] = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Registers at reset: a degenerate segment at the origin.
        query_backlog.push_back(mk(0, 0, 0));
        query_backlog.push_back(mk(MAXC, MAXC, MAXC));
        query_backlog.push_back(mk(MINC, MINC, MINC));
        drain();

        // Directed: a unit segment along x, probing both ends, the interior,
        // both sides, and the far corners.
        s = mk(0, 0, 0);
        e = mk(65536, 0, 0);
        load_segment(s, e);
        query_backlog.push_back(mk(0, 65536, 0));
        query_backlog.push_back(mk(65536, 0, 65536));
        query_backlog.push_back(mk(32768, 3, -7));
        query_backlog.push_back(mk(-1, 0, 0));
        query_backlog.push_back(mk(65537, 0, 0));
        query_backlog.push_back(mk(MAXC, MINC, MAXC));
        query_backlog.push_back(mk(MINC, MAXC, MINC));
        drain();

        // Extremes: the longest possible segment, corner to corner.
        s = mk(MINC, MINC, MINC);
        e = mk(MAXC, MAXC, MAXC);
        load_segment(s, e);
        query_backlog.push_back(mk(MINC, MINC, MINC));
        query_backlog.push_back(mk(MAXC, MAXC, MAXC));
        query_backlog.push_back(mk(MINC, MAXC, MINC));
        query_backlog.push_back(mk(MAXC, MINC, 0));
        query_backlog.push_back(mk(0, 0, 0));
        drain();

        // A short segment at the positive corner: the largest distances, which still fit.
        s = mk(MAXC, MAXC, MAXC);
        e = mk(MAXC, MAXC, MAXC - 1);
        load_segment(s, e);
        query_backlog.push_back(mk(MINC, MINC, MINC));
        query_backlog.push_back(mk(MINC, MINC, MAXC));
        drain();

        // Writes to unused indexes must not disturb the segment.
        write_reg(3'd6, $urandom);
        write_reg(3'd7, $urandom);
        query_backlog.push_back(mk(12345, -54321, 777));
        drain();

        // Random phases: small segments, full-range ones and degenerate ones.
        for (int ph = 0; ph < 12; ph++)
        begin
            if (ph % 4 == 0)
            begin
                s = any_point();
                e = any_point();
            end
            else if (ph % 4 == 3)
            begin
                s = any_point();
                e = s;
            end
            else
            begin
                s = mk(longint'($urandom_range(2000000)) - 1000000,
                       longint'($urandom_range(2000000)) - 1000000,
                       longint'($urandom_range(2000000)) - 1000000);
                e = mk(s.x + longint'($urandom_range(400000)) - 200000,
                       s.y + longint'($urandom_range(400000)) - 200000,
                       s.z + longint'($urandom_range(400000)) - 200000);
            end
            load_segment(s, e);
            random_queries(150);
        end

        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
